/* src/bfce_pkg.sv */
// ----------------------------------------------------------------------------
// bfce_pkg
// Shared types and constants of the bit field copy engine.
// ----------------------------------------------------------------------------
package bfce_pkg;

  localparam int WORD_BITS = 32;

  typedef enum logic [1:0] {
    OP_WR_SRC = 2'd0,
    OP_WR_DST = 2'd1,
    OP_RD_DST = 2'd2,
    OP_COPY   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [5:0]  idx;
    logic [31:0] data;
    logic [10:0] src;
    logic [10:0] dst;
    logic [11:0] len;
    logic        idx_ok;
    logic        range_err;
  } item_t;

  function automatic logic [31:0] low_mask(input logic [5:0] n);
    logic [5:0] sh;
    sh = 6'd32 - n;
    low_mask = 32'hffff_ffff >> sh;
  endfunction

endpackage

/* src/bit_field_copy_engine.sv */
// ----------------------------------------------------------------------------
// bit_field_copy_engine
// Source and destination word stores with a bit field copy between them.
// ----------------------------------------------------------------------------
// Input side is a queue: present a word and raise push while full is low.
// Result side is a single register: while empty is low the result sits on
// read_value and status; raise pop to take it. Each input word gives exactly
// one result, in order.
// A four-deep input queue lets words arrive while the back end is busy.
// With the back end idle, a write or an out-of-range or empty copy shows its
// result in the cycle after acceptance; a read first passes through ST_READ,
// which registers the store word. A copy walks each destination word touched
// (up to 64 for a full 2048-bit copy) in ST_COPY, then ST_DRAIN, paced by the
// single destination write port. The next word is taken the cycle after the
// result is popped, so each word waits until the previous result is taken.
// Reset empties the input queue and the result register and idles the back
// end; store contents are left as they are and must be written before use.
// A stalled result register holds the back end; the input queue keeps filling
// until full.
// ----------------------------------------------------------------------------
module bit_field_copy_engine import bfce_pkg::*; #(
  parameter int STORE_WORDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation,
  input  logic [5:0]  word_addr,
  input  logic [31:0] word_data,
  input  logic [10:0] src_bit_offset,
  input  logic [10:0] dst_bit_offset,
  input  logic [11:0] copy_length,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] read_value,
  output logic        status
);

  logic  item_valid;
  item_t item;
  logic  item_take;

  bfce_front #(.STORE_WORDS(STORE_WORDS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .operation      (operation),
    .word_addr      (word_addr),
    .word_data      (word_data),
    .src_bit_offset (src_bit_offset),
    .dst_bit_offset (dst_bit_offset),
    .copy_length    (copy_length),
    .item_valid     (item_valid),
    .item           (item),
    .item_take      (item_take)
  );

  bfce_back #(.STORE_WORDS(STORE_WORDS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .empty      (empty),
    .pop        (pop),
    .read_value (read_value),
    .status     (status)
  );

  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    item_take |-> item_valid)
    else $error("back end took a word from an empty queue");

  a_status_value: assert property (@(posedge clk) disable iff (rst)
    (!empty && status) |-> (read_value == 32'd0))
    else $error("failed copy carries read data");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not empty after reset");

endmodule

/* src/bfce_front.sv */
// ----------------------------------------------------------------------------
// bfce_front
// Accepts words, checks index and copy range, and queues them for the back end.
// ----------------------------------------------------------------------------
module bfce_front import bfce_pkg::*; #(
  parameter int STORE_WORDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation,
  input  logic [5:0]  word_addr,
  input  logic [31:0] word_data,
  input  logic [10:0] src_bit_offset,
  input  logic [10:0] dst_bit_offset,
  input  logic [11:0] copy_length,
  output logic        item_valid,
  output item_t       item,
  input  logic        item_take
);

  localparam int DEPTH = 4;
  localparam logic [31:0] LIMIT = 32'(WORD_BITS * STORE_WORDS);

  item_t       q [DEPTH];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;
  logic [2:0]  count;
  item_t       in_item;
  logic [12:0] src_end;
  logic [12:0] dst_end;
  logic        do_push;
  logic        do_pop;

  always_comb begin
    src_end = {2'b0, src_bit_offset} + {1'b0, copy_length};
    dst_end = {2'b0, dst_bit_offset} + {1'b0, copy_length};
    in_item.op        = op_t'(operation);
    in_item.idx       = word_addr;
    in_item.data      = word_data;
    in_item.src       = src_bit_offset;
    in_item.dst       = dst_bit_offset;
    in_item.len       = copy_length;
    in_item.idx_ok    = {26'b0, word_addr} < 32'(STORE_WORDS);
    in_item.range_err = ({19'b0, src_end} > LIMIT) || ({19'b0, dst_end} > LIMIT);
  end

  assign full       = count == 3'(DEPTH);
  assign item_valid = count != 3'd0;
  assign item       = q[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 2'd1;
      if (do_pop)  rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'b0, do_push} - {2'b0, do_pop};
    end
  end

endmodule

/* src/bfce_back.sv */
// ----------------------------------------------------------------------------
// bfce_back
// Holds both word stores, runs writes, reads and copies, and holds the result.
// ----------------------------------------------------------------------------
module bfce_back import bfce_pkg::*; #(
  parameter int STORE_WORDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  item_t       item,
  output logic        item_take,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] read_value,
  output logic        status
);

  localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

  logic [31:0] src_mem [STORE_WORDS];
  logic [31:0] dst_mem [STORE_WORDS];

  state_t      state;
  state_t      state_next;

  logic [11:0] s;
  logic [11:0] d;
  logic [11:0] rem;
  logic        rd_ok;

  logic        p_valid;
  logic [4:0]  p_ssh;
  logic [4:0]  p_dsh;
  logic [5:0]  p_n;
  logic [AW-1:0] p_dw;

  logic [31:0] src_q0;
  logic [31:0] src_q1;
  logic [31:0] dst_q;

  logic        out_valid;

  logic [4:0]  sh;
  logic [5:0]  room;
  logic [5:0]  n;
  logic        last;
  logic [31:0] sa0_full;
  logic [31:0] sa1_full;
  logic [31:0] dw_full;
  logic [31:0] idx_full;
  logic [AW-1:0] src_ra0;
  logic [AW-1:0] src_ra1;
  logic [AW-1:0] dst_ra;
  logic [AW-1:0] idx_a;
  logic [AW-1:0] chunk_dw;

  logic        src_we;
  logic        dst_we;
  logic [AW-1:0] dst_wa;
  logic [31:0] dst_wd;
  logic        start_copy;
  logic        set_result;
  logic [31:0] res_value;
  logic        res_status;

  logic [63:0] pair;
  logic [31:0] nmask;
  logic [31:0] fmask;
  logic [31:0] fdata;
  logic [31:0] merged;

  always_comb begin
    sh       = d[4:0];
    room     = 6'd32 - {1'b0, sh};
    n        = (rem < {6'b0, room}) ? rem[5:0] : room;
    last     = rem == {6'b0, n};
    sa0_full = {25'b0, s[11:5]};
    sa1_full = sa0_full + 32'd1;
    dw_full  = {25'b0, d[11:5]};
    idx_full = {26'b0, item.idx};
    src_ra0  = sa0_full[AW-1:0];
    src_ra1  = sa1_full[AW-1:0];
    chunk_dw = dw_full[AW-1:0];
    idx_a    = idx_full[AW-1:0];
    dst_ra   = (state == ST_IDLE) ? idx_a : chunk_dw;
  end

  always_comb begin
    pair   = {src_q1, src_q0} >> p_ssh;
    nmask  = low_mask(p_n);
    fdata  = pair[31:0] & nmask;
    fmask  = nmask << p_dsh;
    merged = (dst_q & ~fmask) | ((fdata << p_dsh) & fmask);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_take) begin
          if (item.op == OP_RD_DST) begin
            state_next = ST_READ;
          end else if (start_copy) begin
            state_next = ST_COPY;
          end
        end
      end
      ST_READ:  state_next = ST_IDLE;
      ST_COPY:  if (last) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_take  = (state == ST_IDLE) && item_valid && !out_valid;
    start_copy = (item.op == OP_COPY) && !item.range_err && (item.len != 12'd0);
    src_we     = item_take && (item.op == OP_WR_SRC) && item.idx_ok;
    dst_we     = p_valid || (item_take && (item.op == OP_WR_DST) && item.idx_ok);
    dst_wa     = p_valid ? p_dw : idx_a;
    dst_wd     = p_valid ? merged : item.data;
    set_result = 1'b0;
    res_value  = '0;
    res_status = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (item_take && (item.op != OP_RD_DST) && !start_copy) begin
          set_result = 1'b1;
          res_status = (item.op == OP_COPY) && item.range_err;
        end
      end
      ST_READ: begin
        set_result = 1'b1;
        res_value  = rd_ok ? dst_q : '0;
      end
      ST_DRAIN: set_result = 1'b1;
      ST_COPY:  set_result = 1'b0;
      default:  set_result = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (src_we) begin
      src_mem[idx_a] <= item.data;
    end
    if (dst_we) begin
      dst_mem[dst_wa] <= dst_wd;
    end
    src_q0 <= src_mem[src_ra0];
    src_q1 <= src_mem[src_ra1];
    dst_q  <= dst_mem[dst_ra];
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      s     <= {1'b0, item.src};
      d     <= {1'b0, item.dst};
      rem   <= item.len;
      rd_ok <= item.idx_ok;
    end else if (state == ST_COPY) begin
      s   <= s + {6'b0, n};
      d   <= d + {6'b0, n};
      rem <= rem - {6'b0, n};
    end
    p_ssh <= s[4:0];
    p_dsh <= sh;
    p_n   <= n;
    p_dw  <= chunk_dw;
    if (set_result) begin
      read_value <= res_value;
      status     <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      p_valid <= state == ST_COPY;
      if (set_result) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty = !out_valid;

endmodule
